[sv/psc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the polar scan converter.
// Used by every module of the block; depends on nothing else.

package psc_pkg;

	localparam int MAX_SAMPLES   = 4096;
	localparam int CORDIC_STAGES = 24;
	localparam int ATAN_LEN      = 32;
	localparam int NUM_ROT       = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	localparam int RANGE_W = 31;
	localparam int ANGLE_W = 32;
	localparam int IDX_W   = 12;
	localparam int COORD_W = 32;
	localparam int CFG_W   = 32;
	localparam int ADDR_W  = 8;

	localparam int IN_DATA_W  = ((RANGE_W + IDX_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_W + IDX_W + 7) / 8) * 8;

	// Angle reduction widths.
	localparam int PROD_W      = IDX_W + ANGLE_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int EST_SHIFT   = 24;
	localparam int EST_W       = SUM_W - EST_SHIFT;
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 24;
	localparam int QP_W        = EST_W + RECIP_W + 1;
	localparam int QUOT_W      = QP_W - RECIP_SHIFT;
	localparam int QD_W        = QUOT_W + 32;
	localparam int RES_W       = 33;
	localparam int ANG_W       = 31;
	localparam int Z_W         = 34;

	// Start vector widths.
	localparam int GAIN_W    = 30;
	localparam int MRAW_W    = RANGE_W + GAIN_W;
	localparam int MAG_SHIFT = 14;
	localparam int MAG_W     = MRAW_W - MAG_SHIFT;
	localparam int XY_W      = MAG_W + 2;
	localparam int FRAC_SHIFT = 16;

	localparam longint PI_Q28      = 64'sd843314857;
	localparam longint TWO_PI_Q28  = 64'sd1686629713;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint KINV_Q30    = 64'sd652032874;
	localparam longint RECIP_2PI   = (64'sd1 <<< (EST_SHIFT + RECIP_SHIFT)) / TWO_PI_Q28;

	localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = '0;
	localparam logic [RANGE_W-1:0] MAX_RANGE_RST   = '1;
	localparam logic [ANGLE_W-1:0] START_ANGLE_RST = ANGLE_W'(-64'sd843314857);
	localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = ANGLE_W'(64'sd4685082);

	typedef enum logic [ADDR_W-1:0] {
		REG_MIN_RANGE   = ADDR_W'(0),
		REG_MAX_RANGE   = ADDR_W'(1),
		REG_START_ANGLE = ADDR_W'(2),
		REG_ANGLE_STEP  = ADDR_W'(3)
	} cfg_reg_t;

	typedef struct packed {
		logic             vld;
		logic             ok;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	function automatic logic [Z_W-1:0] atan_q30(input int i);
		logic [Z_W-1:0] v;
		case (i)
			0:  v = Z_W'(843314857);
			1:  v = Z_W'(497837830);
			2:  v = Z_W'(263043837);
			3:  v = Z_W'(133525159);
			4:  v = Z_W'(67021687);
			5:  v = Z_W'(33543516);
			6:  v = Z_W'(16775851);
			7:  v = Z_W'(8388437);
			8:  v = Z_W'(4194283);
			9:  v = Z_W'(2097149);
			10: v = Z_W'(1048576);
			11: v = Z_W'(524288);
			12: v = Z_W'(262144);
			13: v = Z_W'(131072);
			14: v = Z_W'(65536);
			15: v = Z_W'(32768);
			16: v = Z_W'(16384);
			17: v = Z_W'(8192);
			18: v = Z_W'(4096);
			19: v = Z_W'(2048);
			20: v = Z_W'(1024);
			21: v = Z_W'(512);
			22: v = Z_W'(256);
			23: v = Z_W'(128);
			24: v = Z_W'(64);
			25: v = Z_W'(32);
			26: v = Z_W'(16);
			27: v = Z_W'(8);
			28: v = Z_W'(4);
			29: v = Z_W'(2);
			30: v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/psc_front.sv]
`timescale 1ns / 1ps
// Front pipeline: range window check, beam angle, reduction into (-pi, pi],
// gain-compensated start vector and quadrant pre-rotation. Uses psc_pkg.

module psc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic [psc_pkg::RANGE_W-1:0]           range_sample,
	input  logic                                  sample_finite,
	input  logic [psc_pkg::IDX_W-1:0]             sample_index,
	input  logic [psc_pkg::RANGE_W-1:0]           min_range,
	input  logic [psc_pkg::RANGE_W-1:0]           max_range,
	input  logic signed [psc_pkg::ANGLE_W-1:0]    start_angle,
	input  logic signed [psc_pkg::ANGLE_W-1:0]    angle_step,
	output psc_pkg::ctl_t                         ctl_o,
	output logic signed [psc_pkg::XY_W-1:0]       x_o,
	output logic signed [psc_pkg::XY_W-1:0]       y_o,
	output logic signed [psc_pkg::Z_W-1:0]        z_o
);
	import psc_pkg::*;

	localparam logic [GAIN_W-1:0]          KINV     = GAIN_W'(KINV_Q30);
	localparam logic [MRAW_W-1:0]          MAG_RND  = MRAW_W'(1) << (MAG_SHIFT - 1);
	localparam logic [RECIP_W-1:0]         RECIP    = RECIP_W'(RECIP_2PI);
	localparam logic signed [QD_W-1:0]     D_QD     = QD_W'(TWO_PI_Q28);
	localparam logic signed [RES_W-1:0]    D_RES    = RES_W'(TWO_PI_Q28);
	localparam logic signed [RES_W-1:0]    TWO_D    = RES_W'(2 * TWO_PI_Q28);
	localparam logic [ANG_W-1:0]           D_ANG    = ANG_W'(TWO_PI_Q28);
	localparam logic [ANG_W-1:0]           PI_ANG   = ANG_W'(PI_Q28);
	localparam logic signed [Z_W-1:0]      D_Z      = Z_W'(TWO_PI_Q28);
	localparam logic signed [Z_W-1:0]      HP_Z     = Z_W'(HALF_PI_Q30);
	// A beam at exactly pi leaves a residual slightly above a quarter turn.
	localparam logic signed [Z_W-1:0]      Z_TOP    = Z_W'(4 * PI_Q28 - HALF_PI_Q30);

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic signed [PROD_W-1:0] idx_x, step_x, prod_c, prod_s1;
	logic [MRAW_W-1:0]        mraw_c, mraw_s1;
	logic                     ok_c;

	logic signed [SUM_W-1:0]  sum_s2, sum_s3, sum_s4;
	logic [MAG_W-1:0]         m_s2, m_s3, m_s4, m_s5, m_s6;

	logic signed [EST_W-1:0]  est_c;
	logic signed [QP_W-1:0]   qp_c;
	logic signed [QUOT_W-1:0] q_s3;

	logic signed [QD_W-1:0]   qd_c, qd_s4, diff_c;
	logic signed [RES_W-1:0]  res_s5;
	logic [ANG_W-1:0]         ang_c, ang_s6;

	logic signed [Z_W-1:0]    zw_c, zf_c, z_c, z_s7;
	logic signed [XY_W-1:0]   mx_c, x_c, y_c, x_s7, y_s7;

	// Stage 1: window check, index times step, range times inverse gain.
	assign idx_x  = PROD_W'($signed({1'b0, sample_index}));
	assign step_x = PROD_W'(angle_step);
	assign prod_c = idx_x * step_x;
	assign mraw_c = MRAW_W'(range_sample) * MRAW_W'(KINV);
	assign ok_c   = sample_finite && (range_sample > min_range) &&
	                (range_sample < max_range) && (int'(sample_index) < MAX_SAMPLES);

	// Stage 3: quotient estimate from the top bits of the angle sum.
	assign est_c = $signed(sum_s2[SUM_W-1:EST_SHIFT]);
	assign qp_c  = QP_W'(est_c) * QP_W'($signed({1'b0, RECIP}));

	// Stages 4 and 5: remainder, within one period of the final range.
	assign qd_c   = QD_W'(q_s3) * D_QD;
	assign diff_c = QD_W'(sum_s4) - qd_s4;

	always_comb begin
		if (res_s5 < 0) begin
			ang_c = ANG_W'(res_s5 + D_RES);
		end else if (res_s5 >= D_RES) begin
			ang_c = ANG_W'(res_s5 - D_RES);
		end else begin
			ang_c = ANG_W'(res_s5);
		end
	end

	// Stage 7: wrap into (-pi, pi], scale to Q30 and pre-rotate by a quarter turn when beyond +-pi/2.
	always_comb begin
		zw_c = Z_W'($signed({1'b0, ang_s6}));
		mx_c = XY_W'($signed({1'b0, m_s6}));
		if (ang_s6 > PI_ANG) begin
			zf_c = (zw_c - D_Z) <<< 2;
		end else begin
			zf_c = zw_c <<< 2;
		end
		if (zf_c > HP_Z) begin
			x_c = '0;
			y_c = mx_c;
			z_c = zf_c - HP_Z;
		end else if (zf_c < -HP_Z) begin
			x_c = '0;
			y_c = -mx_c;
			z_c = zf_c + HP_Z;
		end else begin
			x_c = mx_c;
			y_c = '0;
			z_c = zf_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_vld, ok: ok_c, idx: sample_index};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			mraw_s1 <= mraw_c;
			sum_s2  <= SUM_W'(start_angle) + SUM_W'(prod_s1);
			m_s2    <= MAG_W'((mraw_s1 + MAG_RND) >> MAG_SHIFT);
			sum_s3  <= sum_s2;
			m_s3    <= m_s2;
			q_s3    <= qp_c[RECIP_SHIFT +: QUOT_W];
			sum_s4  <= sum_s3;
			m_s4    <= m_s3;
			qd_s4   <= qd_c;
			res_s5  <= diff_c[RES_W-1:0];
			m_s5    <= m_s4;
			ang_s6  <= ang_c;
			m_s6    <= m_s5;
			x_s7    <= x_c;
			y_s7    <= y_c;
			z_s7    <= z_c;
		end
	end

	assign ctl_o = ctl_s7;
	assign x_o   = x_s7;
	assign y_o   = y_s7;
	assign z_o   = z_s7;

	a_res_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.vld |-> (res_s5 >= -D_RES) && (res_s5 < TWO_D))
		else $error("angle remainder estimate out of window");

	a_ang_period: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s6.vld |-> (ang_s6 < D_ANG))
		else $error("reduced angle not below one period");

	a_z_quadrant: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s7.vld |-> (z_s7 <= Z_TOP) && (z_s7 >= -HP_Z))
		else $error("residual angle outside a quarter turn");

endmodule

[sv/psc_cordic.sv]
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// Uses psc_pkg for the stage count and the arctangent table.

module psc_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  psc_pkg::ctl_t                    ctl_i,
	input  logic signed [psc_pkg::XY_W-1:0]  x_i,
	input  logic signed [psc_pkg::XY_W-1:0]  y_i,
	input  logic signed [psc_pkg::Z_W-1:0]   z_i,
	output psc_pkg::ctl_t                    ctl_o,
	output logic signed [psc_pkg::XY_W-1:0]  x_o,
	output logic signed [psc_pkg::XY_W-1:0]  y_o
);
	import psc_pkg::*;

	ctl_t                   rot_ctl_s [NUM_ROT];
	logic signed [XY_W-1:0] rot_x_s   [NUM_ROT];
	logic signed [XY_W-1:0] rot_y_s   [NUM_ROT];
	logic signed [Z_W-1:0]  rot_z_s   [NUM_ROT];

	for (genvar g = 0; g < NUM_ROT; g++) begin : g_rot
		localparam logic signed [Z_W-1:0] ATAN_G = atan_q30(g);

		ctl_t                   c_in;
		logic signed [XY_W-1:0] x_in, y_in;
		logic signed [Z_W-1:0]  z_in;

		if (g == 0) begin : g_head
			assign c_in = ctl_i;
			assign x_in = x_i;
			assign y_in = y_i;
			assign z_in = z_i;
		end else begin : g_body
			assign c_in = rot_ctl_s[g-1];
			assign x_in = rot_x_s[g-1];
			assign y_in = rot_y_s[g-1];
			assign z_in = rot_z_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_ctl_s[g] <= '0;
			end else if (en) begin
				rot_ctl_s[g] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_in[Z_W-1]) begin
					rot_x_s[g] <= x_in - (y_in >>> g);
					rot_y_s[g] <= y_in + (x_in >>> g);
					rot_z_s[g] <= z_in - ATAN_G;
				end else begin
					rot_x_s[g] <= x_in + (y_in >>> g);
					rot_y_s[g] <= y_in - (x_in >>> g);
					rot_z_s[g] <= z_in + ATAN_G;
				end
			end
		end
	end

	assign ctl_o = rot_ctl_s[NUM_ROT-1];
	assign x_o   = rot_x_s[NUM_ROT-1];
	assign y_o   = rot_y_s[NUM_ROT-1];

endmodule

[sv/psc_out.sv]
`timescale 1ns / 1ps
// Output register: rounding to signed Q31.0, saturation, zeroing of invalid points
// and the master-side handshake. Uses psc_pkg.

module psc_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psc_pkg::ctl_t                       ctl_i,
	input  logic signed [psc_pkg::XY_W-1:0]     x_i,
	input  logic signed [psc_pkg::XY_W-1:0]     y_i,
	output logic                                en,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [psc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tuser
);
	import psc_pkg::*;

	localparam int SUM_RW = XY_W + 1;
	localparam int QW     = SUM_RW - FRAC_SHIFT;
	localparam logic signed [SUM_RW-1:0] RND   = SUM_RW'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [QW-1:0]     C_MAX = QW'({1'b0, {(COORD_W-1){1'b1}}});
	localparam logic signed [QW-1:0]     C_MIN = -C_MAX - QW'(1);

	function automatic logic [COORD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
		logic signed [SUM_RW-1:0] s;
		logic signed [QW-1:0]     q;
		logic [COORD_W-1:0]       r;
		s = SUM_RW'(v) + RND;
		q = s[SUM_RW-1:FRAC_SHIFT];
		if (q > C_MAX) begin
			r = C_MAX[COORD_W-1:0];
		end else if (q < C_MIN) begin
			r = C_MIN[COORD_W-1:0];
		end else begin
			r = q[COORD_W-1:0];
		end
		return r;
	endfunction

	logic                    out_vld_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_user_q;
	logic [COORD_W-1:0]      px_c, py_c;

	assign en = !out_vld_q || m_axis_tready;

	always_comb begin
		if (ctl_i.ok) begin
			px_c = round_sat(x_i);
			py_c = round_sat(y_i);
		end else begin
			px_c = '0;
			py_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= OUT_DATA_W'({ctl_i.idx, py_c, px_c});
			out_user_q <= ctl_i.ok;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[sv/polar_scan_to_cartesian.sv]
`timescale 1ns / 1ps
// Top level of the laser scan polar to Cartesian converter: configuration
// registers and the pipeline. Uses psc_pkg, psc_front, psc_cordic and psc_out.
//
//   channel | direction | contents
//   s_axis  | in        | tdata: range_sample, sample_index; tuser: sample_finite
//   m_axis  | out       | tdata: point_x, point_y, point_index; tuser: point_valid
//   cfg     | in        | cfg_we, cfg_addr (register index), cfg_wdata
//
// One word is taken per clock while the output is not blocked; there are seven front stages
// (window check, angle product, reduction by a reciprocal estimate, pre-rotation),
// one stage per CORDIC micro-rotation (24), and the output register.
// Reset clears all valid bits and loads the register defaults.
// When the output register holds a word that is not taken, every stage holds.

module polar_scan_to_cartesian (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// range_sample [30:0], sample_index [42:31], zero fill above
	input  logic [psc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// sample_finite
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// point_x [31:0], point_y [63:32], point_index [75:64], zero fill above
	output logic [psc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// point_valid
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic [psc_pkg::ADDR_W-1:0]           cfg_addr,
	input  logic [psc_pkg::CFG_W-1:0]            cfg_wdata
);
	import psc_pkg::*;

	logic [RANGE_W-1:0]        min_range_q, max_range_q;
	logic signed [ANGLE_W-1:0] start_angle_q, angle_step_q;

	logic                      en;
	ctl_t                      front_ctl, rot_ctl;
	logic signed [XY_W-1:0]    front_x, front_y, rot_x, rot_y;
	logic signed [Z_W-1:0]     front_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q   <= MIN_RANGE_RST;
			max_range_q   <= MAX_RANGE_RST;
			start_angle_q <= START_ANGLE_RST;
			angle_step_q  <= ANGLE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_RANGE:   min_range_q   <= cfg_wdata[RANGE_W-1:0];
				REG_MAX_RANGE:   max_range_q   <= cfg_wdata[RANGE_W-1:0];
				REG_START_ANGLE: start_angle_q <= cfg_wdata[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = en;

	psc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (s_axis_tvalid),
		.range_sample  (s_axis_tdata[RANGE_W-1:0]),
		.sample_finite (s_axis_tuser),
		.sample_index  (s_axis_tdata[RANGE_W +: IDX_W]),
		.min_range     (min_range_q),
		.max_range     (max_range_q),
		.start_angle   (start_angle_q),
		.angle_step    (angle_step_q),
		.ctl_o         (front_ctl),
		.x_o           (front_x),
		.y_o           (front_y),
		.z_o           (front_z)
	);

	psc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (front_ctl),
		.x_i    (front_x),
		.y_i    (front_y),
		.z_i    (front_z),
		.ctl_o  (rot_ctl),
		.x_o    (rot_x),
		.y_o    (rot_y)
	);

	psc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_i         (rot_ctl),
		.x_i           (rot_x),
		.y_i           (rot_y),
		.en            (en),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[2*COORD_W-1:0] == '0))
		else $error("invalid point carries nonzero coordinates");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked output word");

endmodule
